@@ hdl/s5d_pkg.sv @@
// Shared types, codes and constants of the SOCKS5 UDP header deframer.
package s5d_pkg;

  // Default queue depths.
  localparam int unsigned IN_DEPTH  = 2;
  localparam int unsigned OUT_DEPTH = 2;

  // Address type codes as they appear on the wire.
  localparam logic [7:0] WIRE_ATYP_IPV4   = 8'h01;
  localparam logic [7:0] WIRE_ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] WIRE_ATYP_IPV6   = 8'h04;

  // Address lengths in bytes.
  localparam logic [7:0] IPV4_LEN = 8'd4;
  localparam logic [7:0] IPV6_LEN = 8'd16;

  // Header parse phases.
  typedef enum logic [3:0] {
    PH_RSV0,
    PH_RSV1,
    PH_FRAG,
    PH_ATYP,
    PH_ADDR,
    PH_DLEN,
    PH_DOMAIN,
    PH_PORT_HI,
    PH_PORT_LO,
    PH_PAYLOAD
  } phase_e;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_DOMAIN,
    KIND_PAYLOAD,
    KIND_DROP
  } kind_e;

  // Decoded address types.
  typedef enum logic [1:0] {
    ATYP_IPV4,
    ATYP_DOMAIN,
    ATYP_IPV6
  } atyp_e;

  // Drop reasons.
  typedef enum logic [2:0] {
    RSN_NONE,
    RSN_RESERVED,
    RSN_FRAGMENT,
    RSN_ATYP,
    RSN_TRUNCATED
  } drop_reason_e;

  // Input item after classification by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_zero;
    logic       atyp_ok;
    atyp_e      atyp;
  } in_item_t;

  // One result item.
  typedef struct packed {
    kind_e        kind;
    atyp_e        atyp;
    logic [63:0]  addr_hi;
    logic [63:0]  addr_lo;
    logic [15:0]  port;
    logic [7:0]   dlen;
    logic [7:0]   data;
    logic         last;
    drop_reason_e reason;
  } result_t;

endpackage

@@ hdl/s5d_fifo.sv @@
// Small register queue used between the deframer stages.
module s5d_fifo #(
  parameter int unsigned Depth = 2,
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ hdl/s5d_front.sv @@
// Front end: classifies incoming bytes and queues them for the parser.
module s5d_front #(
  parameter int unsigned Depth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_datagram_i,
  output logic               full_o,
  input  logic               pop_i,
  output s5d_pkg::in_item_t  item_o,
  output logic               empty_o
);

  import s5d_pkg::*;

  in_item_t item_in;

  // Byte classification: zero test and address type decode
  always_comb begin
    item_in.data    = data_byte_i;
    item_in.last    = end_of_datagram_i;
    item_in.is_zero = (data_byte_i == 8'h00);
    item_in.atyp_ok = 1'b1;
    item_in.atyp    = ATYP_IPV4;
    unique case (data_byte_i)
      WIRE_ATYP_IPV4:   item_in.atyp = ATYP_IPV4;
      WIRE_ATYP_DOMAIN: item_in.atyp = ATYP_DOMAIN;
      WIRE_ATYP_IPV6:   item_in.atyp = ATYP_IPV6;
      default:          item_in.atyp_ok = 1'b0;
    endcase
  end

  s5d_fifo #(
    .Depth (Depth),
    .Width ($bits(in_item_t))
  ) u_in_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (item_in),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .data_o  (item_o),
    .empty_o (empty_o)
  );

endmodule

@@ hdl/s5d_parse.sv @@
// Back end: header parse state machine, one queued item per cycle while the result queue has room.
module s5d_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  s5d_pkg::in_item_t  item_i,
  output logic               item_pop_o,
  input  logic               res_full_i,
  output logic               res_valid_o,
  output s5d_pkg::result_t   res_o
);

  import s5d_pkg::*;

  phase_e       phase_q, phase_d;
  atyp_e        atyp_q, atyp_d;
  logic [7:0]   left_q, left_d;
  logic [63:0]  acc_hi_q, acc_hi_d;
  logic [63:0]  acc_lo_q, acc_lo_d;
  logic [7:0]   port_hi_q, port_hi_d;
  logic [7:0]   dlen_q, dlen_d;
  logic         discard_q, discard_d;

  logic         fire;
  logic         drop;
  drop_reason_e reason;

  // Take an item whenever the result queue has room
  assign fire       = item_valid_i && !res_full_i;
  assign item_pop_o = fire;

  // Bad header byte and truncation detection
  always_comb begin
    reason = RSN_NONE;
    unique case (phase_q)
      PH_RSV0, PH_RSV1: if (!item_i.is_zero) reason = RSN_RESERVED;
      PH_FRAG:          if (!item_i.is_zero) reason = RSN_FRAGMENT;
      PH_ATYP:          if (!item_i.atyp_ok) reason = RSN_ATYP;
      default:          reason = RSN_NONE;
    endcase
    if (reason == RSN_NONE && item_i.last && phase_q != PH_PORT_LO
        && phase_q != PH_PAYLOAD) begin
      reason = RSN_TRUNCATED;
    end
  end

  assign drop = !discard_q && (reason != RSN_NONE);

  // Next state
  always_comb begin
    phase_d   = phase_q;
    atyp_d    = atyp_q;
    left_d    = left_q;
    acc_hi_d  = acc_hi_q;
    acc_lo_d  = acc_lo_q;
    port_hi_d = port_hi_q;
    dlen_d    = dlen_q;
    discard_d = discard_q;
    if (fire && !discard_q && !drop) begin
      unique case (phase_q)
        PH_RSV0: phase_d = PH_RSV1;
        PH_RSV1: phase_d = PH_FRAG;
        PH_FRAG: phase_d = PH_ATYP;
        PH_ATYP: begin
          atyp_d = item_i.atyp;
          if (item_i.atyp == ATYP_DOMAIN) begin
            phase_d = PH_DLEN;
          end else begin
            left_d  = (item_i.atyp == ATYP_IPV6) ? IPV6_LEN : IPV4_LEN;
            phase_d = PH_ADDR;
          end
        end
        PH_ADDR: begin
          acc_hi_d = {acc_hi_q[55:0], acc_lo_q[63:56]};
          acc_lo_d = {acc_lo_q[55:0], item_i.data};
          left_d   = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = PH_PORT_HI;
        end
        PH_DLEN: begin
          dlen_d  = item_i.data;
          left_d  = item_i.data;
          phase_d = item_i.is_zero ? PH_PORT_HI : PH_DOMAIN;
        end
        PH_DOMAIN: begin
          left_d = left_q - 8'd1;
          if (left_q == 8'd1) phase_d = PH_PORT_HI;
        end
        PH_PORT_HI: begin
          port_hi_d = item_i.data;
          phase_d   = PH_PORT_LO;
        end
        PH_PORT_LO: phase_d = PH_PAYLOAD;
        PH_PAYLOAD: phase_d = PH_PAYLOAD;
        default:    phase_d = PH_RSV0;
      endcase
    end else if (fire && drop) begin
      discard_d = 1'b1;
    end
    // End of datagram always returns to the start state
    if (fire && item_i.last) begin
      phase_d   = PH_RSV0;
      atyp_d    = ATYP_IPV4;
      left_d    = '0;
      acc_hi_d  = '0;
      acc_lo_d  = '0;
      port_hi_d = '0;
      dlen_d    = '0;
      discard_d = 1'b0;
    end
  end

  // Result generation
  always_comb begin
    res_valid_o = 1'b0;
    res_o       = '0;
    if (fire && !discard_q) begin
      if (drop) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_DROP;
        res_o.last  = 1'b1;
        res_o.reason = reason;
      end else begin
        unique case (phase_q)
          PH_DOMAIN: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_DOMAIN;
            res_o.atyp  = ATYP_DOMAIN;
            res_o.dlen  = dlen_q;
            res_o.data  = item_i.data;
          end
          PH_PORT_LO: begin
            res_valid_o   = 1'b1;
            res_o.kind    = KIND_HEADER;
            res_o.atyp    = atyp_q;
            res_o.addr_hi = acc_hi_q;
            res_o.addr_lo = acc_lo_q;
            res_o.port    = {port_hi_q, item_i.data};
            res_o.dlen    = (atyp_q == ATYP_DOMAIN) ? dlen_q : 8'd0;
            res_o.last    = item_i.last;
          end
          PH_PAYLOAD: begin
            res_valid_o = 1'b1;
            res_o.kind  = KIND_PAYLOAD;
            res_o.data  = item_i.data;
            res_o.last  = item_i.last;
          end
          default: res_valid_o = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_RSV0;
      atyp_q    <= ATYP_IPV4;
      left_q    <= '0;
      acc_hi_q  <= '0;
      acc_lo_q  <= '0;
      port_hi_q <= '0;
      dlen_q    <= '0;
      discard_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      atyp_q    <= atyp_d;
      left_q    <= left_d;
      acc_hi_q  <= acc_hi_d;
      acc_lo_q  <= acc_lo_d;
      port_hi_q <= port_hi_d;
      dlen_q    <= dlen_d;
      discard_q <= discard_d;
    end
  end

endmodule

@@ hdl/socks5_udp_header_deframer_core.sv @@
// Top level of the SOCKS5 UDP relay header deframer.
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   input    | push, full           | data_byte_i, end_of_datagram_i
//   result   | pop, empty           | kind_o .. drop_reason_o (one item)
//
// One input byte per cycle sustained while the result queue keeps room; the
// parser handles each queued byte in its phase state machine.
// A result reaches the ports through the input queue, which takes its byte,
// and then the result queue, which takes the result when the parser fires.
// Asynchronous active-low reset empties both queues and puts the parser at
// the first reserved byte.
// A full result queue stalls the parser; input keeps queuing until full rises.
module socks5_udp_header_deframer_core #(
  parameter int unsigned InDepth  = s5d_pkg::IN_DEPTH,
  parameter int unsigned OutDepth = s5d_pkg::OUT_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_datagram_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [1:0]  address_type_o,
  output logic [63:0] address_high_o,
  output logic [63:0] address_low_o,
  output logic [15:0] source_port_o,
  output logic [7:0]  domain_length_o,
  output logic [7:0]  out_byte_o,
  output logic        is_last_o,
  output logic [2:0]  drop_reason_o
);

  import s5d_pkg::*;

  in_item_t item;
  logic     item_empty;
  logic     item_pop;
  logic     res_valid;
  logic     res_full;
  result_t  res_in;
  result_t  res_out;

  s5d_front #(
    .Depth (InDepth)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .data_byte_i       (data_byte_i),
    .end_of_datagram_i (end_of_datagram_i),
    .full_o            (full),
    .pop_i             (item_pop),
    .item_o            (item),
    .empty_o           (item_empty)
  );

  s5d_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!item_empty),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .res_full_i   (res_full),
    .res_valid_o  (res_valid),
    .res_o        (res_in)
  );

  s5d_fifo #(
    .Depth (OutDepth),
    .Width ($bits(result_t))
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign kind_o          = res_out.kind;
  assign address_type_o  = res_out.atyp;
  assign address_high_o  = res_out.addr_hi;
  assign address_low_o   = res_out.addr_lo;
  assign source_port_o   = res_out.port;
  assign domain_length_o = res_out.dlen;
  assign out_byte_o      = res_out.data;
  assign is_last_o       = res_out.last;
  assign drop_reason_o   = res_out.reason;

endmodule

@@ hdl/s5d_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
module s5d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind_o,
  input logic [1:0]  address_type_o,
  input logic [7:0]  out_byte_o,
  input logic        is_last_o,
  input logic [2:0]  drop_reason_o
);

  import s5d_pkg::*;

  // A drop always closes the datagram and names a reason
  a_drop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == KIND_DROP |-> is_last_o && drop_reason_o != RSN_NONE)
    else $error("drop result without last flag or reason");

  // Only drops carry a reason
  a_reason_only_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o != KIND_DROP |-> drop_reason_o == RSN_NONE)
    else $error("reason on a non-drop result");

  // Domain name bytes report the domain address type and never end a datagram
  a_domain_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && kind_o == KIND_DOMAIN |-> address_type_o == ATYP_DOMAIN && !is_last_o)
    else $error("malformed domain name item");

  // A waiting result holds until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(kind_o) && $stable(out_byte_o))
    else $error("result changed while stalled");

endmodule

bind socks5_udp_header_deframer_core s5d_checker u_s5d_checker (.*);
